/* rtl/grp_pkg.sv */
// Shared types and constants of the grid rectangle placer.
package grp_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int DIM_W      = 4;
  localparam int GRID_CFG_W = 7;
  localparam int SLOT_W     = 6;
  localparam int TOTAL_W    = 7;
  localparam int MAX_DIM    = 8;

  localparam logic [GRID_CFG_W-1:0] GRID_CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } grp_status_t;

  typedef enum logic {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } grp_reg_t;

  typedef struct packed {
    logic signed [7:0] origin_x;
    logic signed [7:0] origin_y;
    logic [DIM_W-1:0]  rect_width;
    logic [DIM_W-1:0]  rect_height;
  } grp_req_t;

  typedef struct packed {
    grp_status_t        status;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] placed_total;
  } grp_rsp_t;

endpackage

/* rtl/grp_if.sv */
// Request and result channel interfaces of the grid rectangle placer.
interface grp_req_if;
  import grp_pkg::*;
  logic     valid;
  logic     ready;
  grp_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface grp_rsp_if;
  import grp_pkg::*;
  logic     valid;
  logic     ready;
  grp_rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/grid_rectangle_placer.sv */
// Grid rectangle placer: occupancy grid in one memory, check-then-mark sequencer.
// Flow: an out-of-bounds request goes straight to the result phase; any other request reads
//   the covered cells in turn, then writes them all if all were free and a slot is left.
// Throughput: one request at a time; the next is taken once the result is in the output
//   register. The cell memory has one read port and one write port (one cell per cycle).
// Reset: synchronous, active low; a clearing pass over all GRID_SIDE*GRID_SIDE cells follows,
//   during which no request is taken (configuration writes are still taken).
module grid_rectangle_placer #(
  parameter int GRID_SIDE = 64,
  parameter int MAX_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  grp_req_if.sink                         in_req,
  grp_rsp_if.source                       out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [grp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [grp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [grp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import grp_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(MAX_SLOTS + 1);
  // Wide enough for origin plus extent and for the grid side itself
  localparam int BW    = ($clog2(GRID_SIDE + 1) > 8) ? $clog2(GRID_SIDE + 1) : 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_addr_r;
  logic [GRID_CFG_W-1:0] grid_cols_r;
  logic [GRID_CFG_W-1:0] grid_rows_r;
  logic [CNTW-1:0]       count_r;

  // Walk of the rectangle: column/row within it and the cell address
  logic [DIM_W-1:0]      w_r;
  logic [DIM_W-1:0]      h_r;
  logic [DIM_W-1:0]      x_r;
  logic [DIM_W-1:0]      y_r;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         row_addr_r;
  logic [AW-1:0]         start_addr_r;

  // Read pipeline: a read issued in one cycle is checked in the next
  logic                  iss_done_r;
  logic                  rd_pend_r;
  logic                  rd_last_r;

  grp_status_t           status_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  out_valid_r;
  grp_rsp_t              out_data_r;

  // Cell owner memory: 0 for a free cell, else slot plus one
  logic [CNTW-1:0]       mem [DEPTH];
  logic [CNTW-1:0]       mem_q_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [CNTW-1:0]       mem_wdata;

  grp_req_t              req;
  logic [BW-1:0]         cols_eff;
  logic [BW-1:0]         rows_eff;
  logic                  oob;
  logic [AW-1:0]         start_addr;
  logic                  last_cell;
  logic                  row_end;
  logic [DIM_W-1:0]      x_adv;
  logic [DIM_W-1:0]      y_adv;
  logic [AW-1:0]         addr_adv;
  logic [AW-1:0]         row_addr_adv;
  logic                  cfg_wr;
  grp_reg_t              cfg_sel;

  // ---------------------------------------------------------------------------
  // Configuration port: write in the access phase, read back zero-extended
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = grp_reg_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_GRID_COLS: cfg_prdata = CFG_DATA_W'(grid_cols_r);
      REG_GRID_ROWS: cfg_prdata = CFG_DATA_W'(grid_rows_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bounds check of the offered request; register values above the grid
  // side saturate to it, and any negative origin or bad dimension rejects.
  // ---------------------------------------------------------------------------
  assign req      = in_req.data;
  assign cols_eff = (BW'(grid_cols_r) > BW'(GRID_SIDE)) ? BW'(GRID_SIDE) : BW'(grid_cols_r);
  assign rows_eff = (BW'(grid_rows_r) > BW'(GRID_SIDE)) ? BW'(GRID_SIDE) : BW'(grid_rows_r);

  assign oob = req.origin_x[7] || req.origin_y[7]
            || (req.rect_width == '0) || (req.rect_height == '0)
            || (req.rect_width > DIM_W'(MAX_DIM)) || (req.rect_height > DIM_W'(MAX_DIM))
            || (BW'(req.origin_x[6:0]) + BW'(req.rect_width) > cols_eff)
            || (BW'(req.origin_y[6:0]) + BW'(req.rect_height) > rows_eff);

  // Row stride is the full grid side, so a change of configuration never moves a rectangle
  assign start_addr = AW'(int'(req.origin_y[6:0]) * GRID_SIDE + int'(req.origin_x[6:0]));

  // ---------------------------------------------------------------------------
  // Raster walk over the rectangle, one cell per cycle
  // ---------------------------------------------------------------------------
  assign row_end   = (x_r == w_r - DIM_W'(1));
  assign last_cell = row_end && (y_r == h_r - DIM_W'(1));

  always_comb begin
    if (row_end) begin
      x_adv        = '0;
      y_adv        = y_r + DIM_W'(1);
      row_addr_adv = row_addr_r + AW'(GRID_SIDE);
      addr_adv     = row_addr_r + AW'(GRID_SIDE);
    end else begin
      x_adv        = x_r + DIM_W'(1);
      y_adv        = y_r;
      row_addr_adv = row_addr_r;
      addr_adv     = addr_r + AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Memory port. Read data is used only in the check phase and writes happen only
  // in the marking phase or the clearing pass, and a new request starts only after
  // the last write has landed, so no checked read ever meets a pending write.
  // ---------------------------------------------------------------------------
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : count_r + CNTW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[addr_r];
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clear the grid, take a request, check the bounds, then the covered cells,
  // mark them if all are free and a slot is left; hand the result to the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      grid_cols_r <= GRID_CFG_RESET;
      grid_rows_r <= GRID_CFG_RESET;
      count_r     <= '0;
      iss_done_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_sel)
          REG_GRID_COLS: grid_cols_r <= cfg_pwdata[GRID_CFG_W-1:0];
          REG_GRID_ROWS: grid_rows_r <= cfg_pwdata[GRID_CFG_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once its transfer completes; in the result phase the
      // output register is handled there instead
      if (out_valid_r && out_rsp.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_req.valid) begin
            w_r          <= req.rect_width;
            h_r          <= req.rect_height;
            x_r          <= '0;
            y_r          <= '0;
            addr_r       <= start_addr;
            row_addr_r   <= start_addr;
            start_addr_r <= start_addr;
            iss_done_r   <= 1'b0;
            rd_pend_r    <= 1'b0;
            rd_last_r    <= 1'b0;
            if (oob) begin
              status_r <= ST_BOUNDS;
              slot_r   <= '0;
              state_r  <= S_DONE;
            end else begin
              state_r  <= S_READ;
            end
          end
        end

        S_READ: begin
          // Issue the next read until the last cell has gone out
          if (!iss_done_r) begin
            x_r        <= x_adv;
            y_r        <= y_adv;
            addr_r     <= addr_adv;
            row_addr_r <= row_addr_adv;
            iss_done_r <= last_cell;
          end
          rd_pend_r <= !iss_done_r;
          rd_last_r <= !iss_done_r && last_cell;

          // Check the data of the read issued in the previous cycle
          if (rd_pend_r) begin
            if (mem_q_r != '0) begin
              status_r  <= ST_OVERLAP;
              slot_r    <= '0;
              rd_pend_r <= 1'b0;
              state_r   <= S_DONE;
            end else if (rd_last_r) begin
              rd_pend_r <= 1'b0;
              if (count_r == CNTW'(MAX_SLOTS)) begin
                status_r <= ST_FULL;
                slot_r   <= '0;
                state_r  <= S_DONE;
              end else begin
                x_r        <= '0;
                y_r        <= '0;
                addr_r     <= start_addr_r;
                row_addr_r <= start_addr_r;
                state_r    <= S_WRITE;
              end
            end
          end
        end

        S_WRITE: begin
          x_r        <= x_adv;
          y_r        <= y_adv;
          addr_r     <= addr_adv;
          row_addr_r <= row_addr_adv;
          if (last_cell) begin
            count_r  <= count_r + CNTW'(1);
            status_r <= ST_PLACED;
            slot_r   <= SLOT_W'(count_r);
            state_r  <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free or freeing now
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= status_r;
            out_data_r.slot         <= slot_r;
            out_data_r.placed_total <= TOTAL_W'(count_r);
            state_r                 <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_SLOTS))
    else $error("placed count beyond slot capacity");

  a_count_on_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> $past(state_r == S_WRITE))
    else $error("placed count moved outside the marking phase");

  a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_READ))
    else $error("read data checked without a read issued in the check phase");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished request");

  a_placed_counted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (status_r == ST_PLACED)) |-> (count_r != '0))
    else $error("placement reported without a counted rectangle");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the grid rectangle placer: directed, configuration and random traffic.
`timescale 1ns / 1ps

module tb_top;
  import grp_pkg::*;

  // DUT parameter defaults, mirrored for the grid model
  localparam int GRID_SIDE   = 64;
  localparam int MAX_SLOTS   = 64;
  // upper bound on the run before the watchdog ends it
  localparam int CYCLE_LIMIT = 1_000_000;
  // let the tail run past the longest request (8 by 8)
  localparam int TAIL_CYCLES = 140;
  localparam int SETTLE      = 8;
  localparam int SUB_PHASES  = 5;
  localparam int SUB_ITEMS   = 57;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  grp_req_if req_if ();
  grp_rsp_if rsp_if ();

  grid_rectangle_placer #(
    .GRID_SIDE(GRID_SIDE),
    .MAX_SLOTS(MAX_SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_if),
    .out_rsp    (rsp_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Grid model: one occupancy bit per cell at a fixed row stride of GRID_SIDE,
  // so changing the grid size never moves what is already placed.
  // ---------------------------------------------------------------------------
  bit              cell_taken [GRID_SIDE*GRID_SIDE];
  int              placed_cnt;
  logic [6:0]      cols_cfg;
  logic [6:0]      rows_cfg;
  grp_rsp_t        pending_results[$];

  int              err_cnt;
  int              cfg_writes;
  int              status_seen [4];
  int              cycle_cnt;
  int              req_gap_pct;
  int              rsp_stall_pct;

  // Clamp a grid register to the physical grid side.
  function automatic int usable_dim(input logic [6:0] raw);
    return (raw > GRID_SIDE) ? GRID_SIDE : int'(raw);
  endfunction

  // Work out the answer to one request and update the grid model.
  // Order of rejection: out of bounds, then any taken cell, then a full table.
  function automatic grp_rsp_t place_rect(input grp_req_t r);
    grp_rsp_t res;
    int       ox, oy, w, h, ec, er, x, y;
    bit       clash;
    ox = $signed(r.origin_x);
    oy = $signed(r.origin_y);
    w  = r.rect_width;
    h  = r.rect_height;
    ec = usable_dim(cols_cfg);
    er = usable_dim(rows_cfg);
    res.status = ST_PLACED;
    res.slot   = '0;
    if (ox < 0 || oy < 0 || w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM ||
        ox + w > ec || oy + h > er) begin
      res.status = ST_BOUNDS;
    end else begin
      clash = 1'b0;
      for (y = 0; y < h; y++)
        for (x = 0; x < w; x++)
          if (cell_taken[(oy + y) * GRID_SIDE + ox + x]) clash = 1'b1;
      if (clash) begin
        res.status = ST_OVERLAP;
      end else if (placed_cnt >= MAX_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        res.slot = SLOT_W'(placed_cnt);
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++)
            cell_taken[(oy + y) * GRID_SIDE + ox + x] = 1'b1;
        placed_cnt++;
      end
    end
    res.placed_total = TOTAL_W'(placed_cnt);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random, then check each transfer against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin : rsp_check
    grp_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      status_seen[rsp_if.data.status]++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding (status %0d)", rsp_if.data.status);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.data.status);
          err_cnt++;
        end
        if (rsp_if.data.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, rsp_if.data.slot);
          err_cnt++;
        end
        if (rsp_if.data.placed_total !== want.placed_total) begin
          $error("placed_total: expected %0d, got %0d",
                 want.placed_total, rsp_if.data.placed_total);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request. Valid stays high between back-to-back transfers and is
  // only dropped when the sender decides to idle, so it never gets two
  // assignments in one step.
  task automatic send_req(input grp_req_t r);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < req_gap_pct) begin
      if (!lowered) begin
        req_if.valid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    // transfer taken at this edge: predict now
    pending_results.push_back(place_rect(r));
  endtask

  task automatic send_fields(input int ox, input int oy, input int w, input int h);
    grp_req_t r;
    r.origin_x    = 8'(ox);
    r.origin_y    = 8'(oy);
    r.rect_width  = DIM_W'(w);
    r.rect_height = DIM_W'(h);
    send_req(r);
  endtask

  // Hold the sender until every result is back, then let the block settle
  // before touching registers.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one grid register (junk in the upper bits, which must be ignored),
  // then read it straight back with a back-to-back APB access.
  task automatic write_reg(input grp_reg_t idx, input logic [6:0] val);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = ($urandom() & 32'hFFFF_FF80) | CFG_DATA_W'(val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_GRID_COLS) cols_cfg = val;
    else rows_cfg = val;
    cfg_writes++;
    // readback: psel stays high into the next setup phase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[6:0] !== val) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), val, cfg_prdata[6:0]);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [6:0] cols, input logic [6:0] rows);
    wait_drained();
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_GRID_ROWS, rows);
  endtask

  // Random grid dimension: mostly sensible sizes, with zero, one, the full
  // side and oversized values mixed in.
  function automatic logic [6:0] random_dim();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd127;
      3, 4:    return 7'd64;
      5:       return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(2, 63));
    endcase
  endfunction

  // Mostly rectangles that fit the current grid, small ones favoured and the
  // far edge hit now and then; the rest is raw noise across every field bit.
  function automatic grp_req_t random_req();
    grp_req_t r;
    int       ec, er, w, h;
    ec = usable_dim(cols_cfg);
    er = usable_dim(rows_cfg);
    if ($urandom_range(99) < 20 || ec == 0 || er == 0) begin
      r.origin_x    = 8'($urandom());
      r.origin_y    = 8'($urandom());
      r.rect_width  = DIM_W'($urandom_range(0, 15));
      r.rect_height = DIM_W'($urandom_range(0, 15));
    end else begin
      w = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 3);
      h = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 3);
      if (w > ec) w = ec;
      if (h > er) h = er;
      r.origin_x    = 8'(($urandom_range(7) == 0) ? ec - w : $urandom_range(0, ec - w));
      r.origin_y    = 8'(($urandom_range(7) == 0) ? er - h : $urandom_range(0, er - h));
      r.rect_width  = DIM_W'(w);
      r.rect_height = DIM_W'(h);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write both registers back to their reset values, then placement edges on the full 64 by 64 grid.
  task automatic test_placement_edges();
    write_reg(REG_GRID_COLS, GRID_CFG_RESET);
    write_reg(REG_GRID_ROWS, GRID_CFG_RESET);
    send_fields(0, 0, 1, 1);       // first slot
    send_fields(0, 0, 1, 1);       // same cell again: overlap
    send_fields(56, 56, 8, 8);     // largest rectangle in the far corner
    send_fields(55, 55, 2, 2);     // clips the corner of the one above
    send_fields(56, 0, 8, 1);      // flush with the right edge
    send_fields(57, 0, 8, 1);      // one column past it
    send_fields(0, 57, 1, 8);      // one row past the bottom
    send_fields(-128, 0, 1, 1);    // most negative column
    send_fields(0, -1, 1, 1);      // negative row
    send_fields(127, 127, 1, 1);   // largest positive origin
    send_fields(8, 8, 0, 1);       // zero width
    send_fields(8, 8, 1, 0);       // zero height
    send_fields(8, 8, 9, 1);       // width above the maximum
    send_fields(8, 8, 1, 15);      // height at the field's top value
  endtask

  // Grid size registers at their extremes, including empty and oversized grids.
  task automatic test_grid_settings();
    set_grid(7'd1, 7'd1);
    send_fields(0, 0, 1, 1);       // only cell in range is taken
    send_fields(1, 0, 1, 1);
    set_grid(7'd0, 7'd64);         // no columns: nothing fits
    send_fields(0, 0, 1, 1);
    set_grid(7'd64, 7'd0);         // no rows
    send_fields(10, 10, 1, 1);
    set_grid(7'd127, 7'd127);      // saturates to the physical side
    send_fields(63, 63, 1, 1);
    send_fields(64, 0, 1, 1);
    set_grid(7'd65, 7'd64);
    send_fields(60, 10, 4, 4);
  endtask

  // Random traffic in three idling regimes, several grid sizes in each.
  task automatic test_random_traffic();
    int ph, sp, n;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin req_gap_pct = 38; rsp_stall_pct = 63; end
        1:       begin req_gap_pct = 63; rsp_stall_pct = 38; end
        default: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
      endcase
      for (sp = 0; sp < SUB_PHASES; sp++) begin
        if (sp == 0) set_grid(7'd64, 7'd64);
        else set_grid(random_dim(), random_dim());
        for (n = 0; n < SUB_ITEMS; n++) send_req(random_req());
      end
    end
  endtask

  // Fill any slots still free with single cells, then ask for one more free cell.
  task automatic test_table_full();
    int  idx;
    bit  full_hit;
    set_grid(7'd64, 7'd64);
    full_hit = 1'b0;
    for (idx = 0; idx < GRID_SIDE * GRID_SIDE && !full_hit; idx++) begin
      if (!cell_taken[idx]) begin
        full_hit = (placed_cnt >= MAX_SLOTS);
        send_fields(idx % GRID_SIDE, idx / GRID_SIDE, 1, 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    placed_cnt    = 0;
    cols_cfg      = GRID_CFG_RESET;
    rows_cfg      = GRID_CFG_RESET;
    err_cnt       = 0;
    cfg_writes    = 0;
    cycle_cnt     = 0;
    req_gap_pct   = 38;
    rsp_stall_pct = 63;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_placement_edges();
    test_grid_settings();
    test_random_traffic();
    test_table_full();

    // drain, then let the slowest request time out its latency
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Answers seen: %0d placed, %0d out of bounds, %0d overlapping, %0d table full",
             status_seen[ST_PLACED], status_seen[ST_BOUNDS],
             status_seen[ST_OVERLAP], status_seen[ST_FULL]);
    $display("Grid register writes: %0d; rectangles on the grid: %0d",
             cfg_writes, placed_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
